>>> hdl/thbi_pkg.sv
`default_nettype none
package thbi_pkg;

   localparam int MAX_BINS    = 4096;
   localparam int MAX_SLOTS   = 32;
   localparam int ITEM_BITS   = 20;
   localparam int HASH_BITS   = 64;
   localparam int NUM_HASHES  = 3;
   localparam int BIN_BITS    = $clog2(MAX_BINS);
   localparam int SLOT_BITS   = $clog2(MAX_SLOTS);
   localparam int COUNT_BITS  = 13;
   localparam int LIMIT_BITS  = 6;
   localparam int FILL_BITS   = 6;
   localparam int CHOICE_BITS = 2;
   localparam int ENTRY_BITS  = ITEM_BITS + CHOICE_BITS;
   localparam int CSR_BITS    = 13;

   localparam logic [COUNT_BITS-1:0] BIN_COUNT_RESET = COUNT_BITS'(MAX_BINS);
   localparam logic [LIMIT_BITS-1:0] BIN_LIMIT_RESET = LIMIT_BITS'(MAX_SLOTS);

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_READ   = 1'b1
   } opcode_type;

   typedef enum logic {
      CSR_BIN_COUNT = 1'b0,
      CSR_BIN_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [0:0]           opcode;
      logic [ITEM_BITS-1:0] item_index;
      logic [HASH_BITS-1:0] hash_0;
      logic [HASH_BITS-1:0] hash_1;
      logic [HASH_BITS-1:0] hash_2;
      logic [BIN_BITS-1:0]  read_bin;
      logic [SLOT_BITS-1:0] read_slot;
   } req_type;

   typedef struct packed {
      logic [BIN_BITS-1:0]    bin;
      logic [SLOT_BITS-1:0]   slot;
      logic [ITEM_BITS-1:0]   entry_item;
      logic [CHOICE_BITS-1:0] hash_choice;
      logic                   overflow;
      logic                   entry_valid;
      logic                   last;
   } rsp_type;

endpackage
`default_nettype wire

>>> hdl/three_hash_bin_inserter.sv
`default_nettype none
// Sequence: an insert word runs the remainder work in MOD, then for each hash an FRD state
//   (fill-count read) and a FUSE state (write-back and result), three results in all;
//   a read word goes through FRD and FUSE to its one result. Output stalls hold FUSE.
// Throughput: one word at a time, set by the bit-serial modulo and the single fill-count port.
// Reset: synchronous, active high; afterwards the block sweeps the 4096 fill counts to
//   zero and stalls the request side until the sweep is done.
module three_hash_bin_inserter import thbi_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_write,
   input  wire logic [0:0]           csr_index,
   input  wire logic [CSR_BITS-1:0]  csr_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_FRD,
      ST_FUSE
   } state_type;

   state_type                  state_ff, state_in;
   logic [BIN_BITS-1:0]        clr_addr_ff, clr_addr_in;
   logic [CHOICE_BITS-1:0]     choice_ff, choice_in;
   logic                       op_ff, op_in;
   logic [ITEM_BITS-1:0]       item_ff, item_in;
   logic [BIN_BITS-1:0]        rbin_ff, rbin_in;
   logic [SLOT_BITS-1:0]       rslot_ff, rslot_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;
   logic [COUNT_BITS-1:0]      bin_count_ff;
   logic [LIMIT_BITS-1:0]      bin_limit_ff;

   logic [COUNT_BITS-1:0]      nbins;
   logic [LIMIT_BITS-1:0]      limit;
   logic                       accept, emit, ovf, rd_valid;
   logic                       mod_start, mod_done;
   logic [NUM_HASHES-1:0][BIN_BITS-1:0] rems;
   logic [BIN_BITS-1:0]        cur_bin;

   logic                       fill_we, fill_re;
   logic [BIN_BITS-1:0]        fill_addr;
   logic [FILL_BITS-1:0]       fill_wdata, fill_rdata;
   logic                       ent_we, ent_re;
   logic [BIN_BITS+SLOT_BITS-1:0] ent_addr;
   logic [ENTRY_BITS-1:0]      ent_wdata, ent_rdata;

   // Configuration: take writes as they come; writes are to be made only while idle, which the block does not enforce.
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= BIN_COUNT_RESET;
         bin_limit_ff <= BIN_LIMIT_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_BIN_COUNT) begin
            bin_count_ff <= csr_data;
         end else begin
            bin_limit_ff <= csr_data[LIMIT_BITS-1:0];
         end
      end
   end

   // Clamp the modulus to 1..MAX_BINS and the limit to MAX_SLOTS.
   always_comb begin
      nbins = bin_count_ff;
      if (bin_count_ff == '0) begin
         nbins = COUNT_BITS'(1);
      end else if (bin_count_ff > COUNT_BITS'(MAX_BINS)) begin
         nbins = COUNT_BITS'(MAX_BINS);
      end
      limit = (bin_limit_ff > LIMIT_BITS'(MAX_SLOTS)) ? LIMIT_BITS'(MAX_SLOTS) : bin_limit_ff;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign mod_start = accept && (req_data.opcode == OP_INSERT);

   thbi_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .hashes  ({req_data.hash_2, req_data.hash_1, req_data.hash_0}),
      .modulus (nbins),
      .done    (mod_done),
      .rems    (rems)
   );

   // Bin under work: the current hash's remainder on insert, the requested bin on read.
   assign cur_bin = (op_ff == OP_READ) ? rbin_ff : rems[choice_ff];

   // Emit only when the output register is free or drains this cycle.
   assign emit     = (state_ff == ST_FUSE) && (!rsp_valid_ff || !rsp_stall);
   assign ovf      = (fill_rdata >= FILL_BITS'(limit));
   assign rd_valid = (FILL_BITS'(rslot_ff) < fill_rdata);

   // Fill-count memory: sweep on clear, read in FRD, write back on a placed entry.
   assign fill_re    = (state_ff == ST_FRD);
   assign fill_we    = (state_ff == ST_CLEAR) || (emit && (op_ff == OP_INSERT) && !ovf);
   assign fill_addr  = (state_ff == ST_CLEAR) ? clr_addr_ff : cur_bin;
   assign fill_wdata = (state_ff == ST_CLEAR) ? '0 : fill_rdata + 1'b1;

   thbi_ram #(.ADDR_BITS(BIN_BITS), .DATA_BITS(FILL_BITS)) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .rd_en   (fill_re),
      .addr    (fill_addr),
      .wr_data (fill_wdata),
      .rd_data (fill_rdata)
   );

   // Entry memory: read alongside the fill count on read, write at the fill slot on insert.
   assign ent_re    = (state_ff == ST_FRD) && (op_ff == OP_READ);
   assign ent_we    = emit && (op_ff == OP_INSERT) && !ovf;
   assign ent_addr  = (op_ff == OP_READ) ? {rbin_ff, rslot_ff}
                                         : {cur_bin, fill_rdata[SLOT_BITS-1:0]};
   assign ent_wdata = {item_ff, choice_ff};

   thbi_ram #(.ADDR_BITS(BIN_BITS+SLOT_BITS), .DATA_BITS(ENTRY_BITS)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .rd_en   (ent_re),
      .addr    (ent_addr),
      .wr_data (ent_wdata),
      .rd_data (ent_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      choice_in    = choice_ff;
      op_in        = op_ff;
      item_in      = item_ff;
      rbin_in      = rbin_ff;
      rslot_in     = rslot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_data.opcode;
               item_in   = req_data.item_index;
               rbin_in   = req_data.read_bin;
               rslot_in  = req_data.read_slot;
               choice_in = '0;
               state_in  = (req_data.opcode == OP_INSERT) ? ST_MOD : ST_FRD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = ST_FRD;
            end
         end
         ST_FRD: begin
            state_in = ST_FUSE;
         end
         ST_FUSE: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               if (op_ff == OP_INSERT) begin
                  rsp_in.bin         = cur_bin;
                  rsp_in.slot        = ovf ? '0 : fill_rdata[SLOT_BITS-1:0];
                  rsp_in.entry_item  = item_ff;
                  rsp_in.hash_choice = choice_ff;
                  rsp_in.overflow    = ovf;
                  rsp_in.entry_valid = 1'b0;
                  rsp_in.last        = (choice_ff == CHOICE_BITS'(NUM_HASHES - 1));
                  if (choice_ff == CHOICE_BITS'(NUM_HASHES - 1)) begin
                     state_in = ST_IDLE;
                  end else begin
                     choice_in = choice_ff + 1'b1;
                     state_in  = ST_FRD;
                  end
               end else begin
                  rsp_in.bin         = rbin_ff;
                  rsp_in.slot        = rslot_ff;
                  rsp_in.entry_item  = rd_valid ? ent_rdata[ENTRY_BITS-1:CHOICE_BITS] : '0;
                  rsp_in.hash_choice = rd_valid ? ent_rdata[CHOICE_BITS-1:0] : '0;
                  rsp_in.overflow    = 1'b0;
                  rsp_in.entry_valid = rd_valid;
                  rsp_in.last        = 1'b1;
                  state_in           = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      choice_ff <= choice_in;
      op_ff     <= op_in;
      item_ff   <= item_in;
      rbin_ff   <= rbin_in;
      rslot_ff  <= rslot_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

>>> hdl/thbi_ram.sv
`default_nettype none
module thbi_ram #(
   parameter int ADDR_BITS = 12,
   parameter int DATA_BITS = 6
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/thbi_mod.sv
`default_nettype none
module thbi_mod import thbi_pkg::*; (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [NUM_HASHES-1:0][HASH_BITS-1:0]  hashes,
   input  wire logic [COUNT_BITS-1:0]                 modulus,
   output logic                                       done,
   output logic      [NUM_HASHES-1:0][BIN_BITS-1:0]   rems
);

   localparam int CNT_BITS = $clog2(HASH_BITS);

   logic                                 busy_ff, busy_in;
   logic [CNT_BITS-1:0]                  cnt_ff, cnt_in;
   logic [NUM_HASHES-1:0][HASH_BITS-1:0] sh_ff, sh_in;
   logic [NUM_HASHES-1:0][BIN_BITS-1:0]  rem_ff, rem_in;
   logic [NUM_HASHES-1:0][COUNT_BITS-1:0] trial;

   // one remainder bit per cycle and lane: shift in, subtract when at or above modulus
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      done    = 1'b0;
      for (int k = 0; k < NUM_HASHES; k++) begin
         trial[k] = {rem_ff[k], sh_ff[k][HASH_BITS-1]};
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sh_in   = hashes;
         rem_in  = '0;
      end else if (busy_ff) begin
         for (int k = 0; k < NUM_HASHES; k++) begin
            sh_in[k]  = {sh_ff[k][HASH_BITS-2:0], 1'b0};
            rem_in[k] = (trial[k] >= modulus) ? BIN_BITS'(trial[k] - modulus)
                                              : BIN_BITS'(trial[k]);
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(HASH_BITS - 1)) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
   end

   assign rems = rem_ff;

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import thbi_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 120;   // more than one insert word's latency without output stalls
   localparam int HOLD_CYCLES = 400;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_write = 1'b0;
   logic [0:0]          csr_index = '0;
   logic [CSR_BITS-1:0] csr_data = '0;

   three_hash_bin_inserter u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // mirror of the block state
   logic [FILL_BITS-1:0]   fill_mirror [MAX_BINS];
   logic [ENTRY_BITS-1:0]  entry_mirror [MAX_BINS*MAX_SLOTS];
   logic [COUNT_BITS-1:0]  count_reg;
   logic [LIMIT_BITS-1:0]  limit_reg;

   req_type pending_words[$];
   rsp_type expected_rsp[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic        hold_request = 1'b0;
   int unsigned hold_left = 0;
   int unsigned errors = 0;
   int unsigned cycles = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Effective modulus: zero acts as one, saturate at the bin array size.
   function automatic longint unsigned eff_bins();
      if (count_reg == 0) return 1;
      if (count_reg > MAX_BINS) return MAX_BINS;
      return count_reg;
   endfunction

   // Work out the results of one accepted word and advance the mirror.
   task automatic place_word(input req_type w);
      rsp_type r;
      longint unsigned nb;
      int unsigned lim, b, f;
      logic [HASH_BITS-1:0] h;
      if (w.opcode == OP_INSERT) begin
         nb = eff_bins();
         lim = (limit_reg > MAX_SLOTS) ? MAX_SLOTS : limit_reg;
         for (int j = 0; j < NUM_HASHES; j++) begin
            h = (j == 0) ? w.hash_0 : (j == 1) ? w.hash_1 : w.hash_2;
            b = int'(h % nb);
            f = fill_mirror[b];
            r = '0;
            r.bin = BIN_BITS'(b);
            r.entry_item = w.item_index;
            r.hash_choice = CHOICE_BITS'(j);
            r.last = (j == NUM_HASHES-1);
            if (f >= lim) begin
               r.overflow = 1'b1;
            end else begin
               r.slot = SLOT_BITS'(f);
               entry_mirror[b*MAX_SLOTS+f] = {w.item_index, CHOICE_BITS'(j)};
               fill_mirror[b] = FILL_BITS'(f + 1);
            end
            expected_rsp.push_back(r);
         end
      end else begin
         r = '0;
         r.bin = w.read_bin;
         r.slot = w.read_slot;
         r.last = 1'b1;
         if (w.read_slot < fill_mirror[w.read_bin]) begin
            {r.entry_item, r.hash_choice} = entry_mirror[w.read_bin*MAX_SLOTS+w.read_slot];
            r.entry_valid = 1'b1;
         end
         expected_rsp.push_back(r);
      end
   endtask

   // Driver: hold a stalled word, advance on acceptance.
   always @(posedge clock) begin
      req_type nxt;
      logic    go;
      if (!reset) begin
         if (req_valid && !req_stall) place_word(req_data);
         if (!req_valid || !req_stall) begin
            go = (pending_words.size() > 0) && ($urandom_range(99) >= send_idle_pct);
            nxt = req_data;
            if (go) nxt = pending_words.pop_front();
            req_valid <= go;
            req_data <= nxt;
         end
      end
   end

   // Receiver stall, with a long hold-off on request.
   always @(posedge clock) begin
      if (hold_request) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Monitor: check each accepted result against the oldest expectation.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t unexpected result: actual %p", $time, rsp_data);
         end else begin
            e = expected_rsp.pop_front();
            if (e.bin !== rsp_data.bin || e.slot !== rsp_data.slot ||
                e.entry_item !== rsp_data.entry_item ||
                e.hash_choice !== rsp_data.hash_choice ||
                e.overflow !== rsp_data.overflow ||
                e.entry_valid !== rsp_data.entry_valid || e.last !== rsp_data.last) begin
               errors++;
               $display("%0t mismatch: expected %p actual %p", $time, e, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [HASH_BITS-1:0] rand_hash();
      return {$urandom, $urandom};
   endfunction

   // Mostly inserts and reads aimed at bins in use; a few reads anywhere.
   function automatic req_type rand_word();
      req_type w;
      longint unsigned nb;
      nb = eff_bins();
      w.opcode = ($urandom_range(99) < 70) ? OP_INSERT : OP_READ;
      w.item_index = ITEM_BITS'($urandom);
      w.hash_0 = rand_hash();
      w.hash_1 = rand_hash();
      w.hash_2 = rand_hash();
      w.read_bin = ($urandom_range(9) < 8) ? BIN_BITS'($urandom_range(int'(nb) - 1))
                                           : BIN_BITS'($urandom);
      w.read_slot = ($urandom_range(1)) ? SLOT_BITS'($urandom_range(7))
                                        : SLOT_BITS'($urandom);
      return w;
   endfunction

   // Recheck after the drain: the last word may have been popped in the same step.
   task automatic wait_quiet();
      forever begin
         while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0)
            @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (pending_words.size() == 0 && !req_valid && expected_rsp.size() == 0) break;
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_BITS-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_BIN_COUNT) count_reg = val;
      else limit_reg = LIMIT_BITS'(val);
   endtask

   initial begin
      req_type w;
      int unsigned counts [7] = '{4096, 1, 0, 8191, 7, 3, 3};
      int unsigned limits [7] = '{32, 32, 4, 63, 0, 5, 2};
      int unsigned sidle [7] = '{0, 0, 51, 0, 10, 0, 51};
      int unsigned rstall [7] = '{0, 0, 0, 51, 10, 0, 51};
      for (int i = 0; i < MAX_BINS; i++) fill_mirror[i] = '0;
      count_reg = BIN_COUNT_RESET;
      limit_reg = BIN_LIMIT_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < 7; p++) begin
         wait_quiet();
         send_idle_pct = sidle[p];
         recv_stall_pct = rstall[p];
         write_csr(CSR_BIN_COUNT, CSR_BITS'(counts[p]));
         write_csr(CSR_BIN_LIMIT, CSR_BITS'(limits[p]));
         if (p == 0) begin
            // extremes: zero and all-ones hashes, widest item, reads of bins 0 and 4095
            w = '0;
            pending_words.push_back(w);
            w = '1; w.opcode = OP_INSERT;
            pending_words.push_back(w);
            w.item_index = '0; w.hash_0 = 64'd4095; w.hash_1 = 64'd4096; w.hash_2 = 64'd1;
            pending_words.push_back(w);
            w = '0; w.opcode = OP_READ;
            pending_words.push_back(w);
            w.read_slot = 5'd1;
            pending_words.push_back(w);
            w.read_slot = '1;
            pending_words.push_back(w);
            w = '1; w.opcode = OP_READ; w.read_slot = '0;
            pending_words.push_back(w);
            w.read_slot = 5'd2;
            pending_words.push_back(w);
            for (int k = 0; k < 10; k++) pending_words.push_back(rand_word());
         end else begin
            if (p == 1) hold_request <= 1'b1;
            for (int k = 0; k < 75; k++) pending_words.push_back(rand_word());
            @(posedge clock);
            hold_request <= 1'b0;
         end
      end
      wait_quiet();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
